@@ hw/rtl/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin tick scheduler
// Queue geometry, event codes and the result item that the result buffer
// carries between the scheduler core and its output port.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Ready queue geometry.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QidxW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW        = $clog2(QUEUE_DEPTH + 1);

  // Result buffer geometry. It must hold at least two results.
  localparam int unsigned ResDepth    = 4;
  localparam int unsigned ResPtrW     = $clog2(ResDepth);
  localparam int unsigned ResCntW     = $clog2(ResDepth + 1);

  // Field widths.
  localparam int unsigned PidW        = 16;
  localparam int unsigned BurstW      = 16;
  localparam int unsigned QuantW      = 16;
  localparam int unsigned TimeW       = 32;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_STEP   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_IDLE   = 2'd0,
    EV_RUN    = 2'd1,
    EV_DONE   = 2'd2,
    EV_REJECT = 2'd3
  } ev_kind_e;

  // One result item.
  typedef struct packed {
    ev_kind_e          kind;
    logic [PidW-1:0]   pid;
    logic [TimeW-1:0]  stamp;
    logic              last;
  } res_t;

  // Push request from the scheduler core into the result buffer.
  typedef struct packed {
    logic first;   // one result is written
    logic second;  // a second result follows the first in the same cycle
  } res_push_t;

  // Status from the result buffer back to the scheduler core.
  typedef struct packed {
    logic room_for_two;  // at least two free entries
  } res_status_t;

endpackage

@@ hw/rtl/rrts_res_fifo.sv @@
// ----------------------------------------------------------------------------
// rrts_res_fifo: result buffer of the round-robin tick scheduler
// A small FIFO that takes up to two result items per cycle and hands out
// one item per cycle, while not stalled, on a valid/stall output channel.
// ----------------------------------------------------------------------------
module rrts_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrts_pkg::res_push_t   push_i,
  input  rrts_pkg::res_t        res0_i,
  input  rrts_pkg::res_t        res1_i,
  output rrts_pkg::res_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rrts_pkg::res_t        out_res_o
);

  rrts_pkg::res_t                 mem_q [rrts_pkg::ResDepth];
  logic [rrts_pkg::ResPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [rrts_pkg::ResPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [rrts_pkg::ResCntW-1:0]   count_q, count_d;
  logic [rrts_pkg::ResPtrW-1:0]   wr_ptr_nx;
  logic                           pop;

  assign wr_ptr_nx   = wr_ptr_q + rrts_pkg::ResPtrW'(1);
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign status_o.room_for_two = (count_q <= rrts_pkg::ResCntW'(rrts_pkg::ResDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.first && push_i.second) begin
      wr_ptr_d = wr_ptr_q + rrts_pkg::ResPtrW'(2);
      count_d  = count_d + rrts_pkg::ResCntW'(2);
    end else if (push_i.first) begin
      wr_ptr_d = wr_ptr_nx;
      count_d  = count_d + rrts_pkg::ResCntW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + rrts_pkg::ResPtrW'(1);
      count_d  = count_d - rrts_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push_i.first && push_i.second) begin
      mem_q[wr_ptr_nx] <= res1_i;
    end
  end

endmodule

@@ hw/rtl/round_robin_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler: round-robin ready queue with a tick counter
// Arrive items enqueue processes or are rejected when the queue is full; step
// items run one scheduler pass on the head of the queue and report idle, running or finished events.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  operation, process_id,
//                                                burst_time, is_critical
//   out      output     out_valid_o/out_stall_i  event_kind, event_pid,
//                                                event_time, last
//   cfg      input      cfg_valid_i/cfg_ready_o  quantum (16 bit)
//
// Flow: each item is handled in the cycle it is accepted, so one item can be
// accepted every cycle while in_stall_o is low; its results enter the result
// buffer and leave it one result per cycle while out_stall_i is low. The limit
// is the output channel: a critical step puts out two results, one after the other.
// Stalls: in_stall_o is raised while the four-entry result buffer has fewer
// than two free entries, so a stalled output backs up into the input. It is
// also raised while a quantum write is presented.
// Reset: clears the queue pointers, fill count and time and loads the
// quantum with one. The queue storage itself is not cleared; only occupied
// entries are ever read. There is no clearing pass after reset.
//
module round_robin_tick_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] process_id_i,
  input  logic [15:0] burst_time_i,
  input  logic        is_critical_i,
  // Result item channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [15:0] event_pid_o,
  output logic [31:0] event_time_o,
  output logic        last_o,
  // Configuration write channel for the quantum.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // Ready queue storage. It is written at one address per cycle (the tail,
  // or the head for a tick) and read only at the head.
  logic [rrts_pkg::PidW-1:0]    q_pid_q  [rrts_pkg::QUEUE_DEPTH];
  logic [rrts_pkg::BurstW-1:0]  q_rem_q  [rrts_pkg::QUEUE_DEPTH];
  logic                         q_crit_q [rrts_pkg::QUEUE_DEPTH];

  logic [rrts_pkg::QidxW-1:0]   head_q, head_d;
  logic [rrts_pkg::QidxW-1:0]   tail_q, tail_d;
  logic [rrts_pkg::CntW-1:0]    count_q, count_d;
  logic [rrts_pkg::TimeW-1:0]   time_q, time_d;
  logic [rrts_pkg::QuantW-1:0]  quant_q, quant_d;
  logic [rrts_pkg::QuantW-1:0]  quant_left_q, quant_left_d;

  // Queue write port.
  logic                         wr_en;
  logic [rrts_pkg::QidxW-1:0]   wr_addr;
  logic [rrts_pkg::PidW-1:0]    wr_pid;
  logic [rrts_pkg::BurstW-1:0]  wr_rem;
  logic                         wr_crit;

  // Head entry and derived values.
  logic [rrts_pkg::PidW-1:0]    h_pid;
  logic [rrts_pkg::BurstW-1:0]  h_rem;
  logic                         h_crit;
  logic [rrts_pkg::QidxW-1:0]   head_nx, tail_nx;
  logic [rrts_pkg::QuantW-1:0]  reload_val;
  logic [rrts_pkg::TimeW:0]     sum_one, sum_rem;
  logic [rrts_pkg::TimeW-1:0]   time_plus_one, time_plus_rem;
  logic                         q_full, q_empty;

  logic                         in_accept;
  rrts_pkg::op_e                op;
  rrts_pkg::res_push_t          push;
  rrts_pkg::res_status_t        res_status;
  rrts_pkg::res_t               res0, res1, out_res;

  function automatic logic [rrts_pkg::QidxW-1:0] wrap_next(
    input logic [rrts_pkg::QidxW-1:0] p
  );
    logic [rrts_pkg::QidxW-1:0] r;
    r = (p == rrts_pkg::QidxW'(rrts_pkg::QUEUE_DEPTH - 1)) ? '0
                                                            : p + rrts_pkg::QidxW'(1);
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  // A quantum write takes the cycle, so no item is taken beside it.
  assign in_stall_o  = !res_status.room_for_two || cfg_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign op          = rrts_pkg::op_e'(operation_i);

  assign h_pid   = q_pid_q[head_q];
  assign h_rem   = q_rem_q[head_q];
  assign h_crit  = q_crit_q[head_q];
  assign head_nx = wrap_next(head_q);
  assign tail_nx = wrap_next(tail_q);
  assign q_full  = (count_q == rrts_pkg::CntW'(rrts_pkg::QUEUE_DEPTH));
  assign q_empty = (count_q == '0);

  // A quantum of zero counts as one whenever it is loaded.
  assign reload_val = (quant_q == '0) ? rrts_pkg::QuantW'(1) : quant_q;

  // Time advances saturate at the all-ones value.
  assign sum_one       = {1'b0, time_q} + (rrts_pkg::TimeW + 1)'(1);
  assign sum_rem       = {1'b0, time_q} + (rrts_pkg::TimeW + 1)'(h_rem);
  assign time_plus_one = sum_one[rrts_pkg::TimeW] ? '1 : sum_one[rrts_pkg::TimeW-1:0];
  assign time_plus_rem = sum_rem[rrts_pkg::TimeW] ? '1 : sum_rem[rrts_pkg::TimeW-1:0];

  // One scheduler pass per accepted item.
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    time_d       = time_q;
    quant_d      = quant_q;
    quant_left_d = quant_left_q;
    wr_en        = 1'b0;
    wr_addr      = tail_q;
    wr_pid       = process_id_i;
    wr_rem       = burst_time_i;
    wr_crit      = is_critical_i;
    push         = '0;
    res0         = '{kind: rrts_pkg::EV_IDLE, pid: '0, stamp: time_q, last: 1'b1};
    res1         = '{kind: rrts_pkg::EV_DONE, pid: h_pid, stamp: time_plus_rem,
                     last: 1'b1};

    if (cfg_valid_i && cfg_ready_o) begin
      // Writing the register also reloads the running quantum.
      quant_d      = cfg_data_i;
      quant_left_d = (cfg_data_i == '0) ? rrts_pkg::QuantW'(1) : cfg_data_i;
    end else if (in_accept) begin
      unique case (op)
        rrts_pkg::OP_ARRIVE: begin
          if (q_full) begin
            push.first = 1'b1;
            res0.kind  = rrts_pkg::EV_REJECT;
            res0.pid   = process_id_i;
          end else begin
            wr_en   = 1'b1;
            tail_d  = tail_nx;
            count_d = count_q + rrts_pkg::CntW'(1);
          end
        end
        rrts_pkg::OP_STEP: begin
          priority if (q_empty) begin
            push.first = 1'b1;
            time_d     = time_plus_one;
          end else if (h_crit) begin
            // A critical process runs to completion in one pass.
            push.first   = 1'b1;
            push.second  = 1'b1;
            res0.kind    = rrts_pkg::EV_RUN;
            res0.pid     = h_pid;
            res0.last    = 1'b0;
            time_d       = time_plus_rem;
            head_d       = head_nx;
            count_d      = count_q - rrts_pkg::CntW'(1);
            quant_left_d = reload_val;
          end else if (h_rem == '0) begin
            push.first   = 1'b1;
            res0.kind    = rrts_pkg::EV_DONE;
            res0.pid     = h_pid;
            head_d       = head_nx;
            count_d      = count_q - rrts_pkg::CntW'(1);
            quant_left_d = reload_val;
          end else if (quant_left_q == '0) begin
            // Quantum used up: the head entry moves to the tail silently.
            wr_en        = 1'b1;
            wr_pid       = h_pid;
            wr_rem       = h_rem;
            wr_crit      = h_crit;
            tail_d       = tail_nx;
            head_d       = head_nx;
            quant_left_d = reload_val;
          end else begin
            push.first   = 1'b1;
            res0.kind    = rrts_pkg::EV_RUN;
            res0.pid     = h_pid;
            wr_en        = 1'b1;
            wr_addr      = head_q;
            wr_pid       = h_pid;
            wr_rem       = h_rem - rrts_pkg::BurstW'(1);
            wr_crit      = h_crit;
            quant_left_d = quant_left_q - rrts_pkg::QuantW'(1);
            time_d       = time_plus_one;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      time_q       <= '0;
      quant_q      <= rrts_pkg::QuantW'(1);
      quant_left_q <= rrts_pkg::QuantW'(1);
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      time_q       <= time_d;
      quant_q      <= quant_d;
      quant_left_q <= quant_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_pid_q[wr_addr]  <= wr_pid;
      q_rem_q[wr_addr]  <= wr_rem;
      q_crit_q[wr_addr] <= wr_crit;
    end
  end

  rrts_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .status_o    (res_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign event_kind_o  = out_res.kind;
  assign event_pid_o   = out_res.pid;
  assign event_time_o  = out_res.stamp;
  assign last_o        = out_res.last;

`ifndef SYNTHESIS
  // The fill count never passes the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rrts_pkg::CntW'(rrts_pkg::QUEUE_DEPTH))
    else $error("queue fill count above depth");

  // Scheduler time never runs backwards.
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q >= $past(time_q))
    else $error("scheduler time decreased");

  // A second result is only ever pushed together with a first one.
  a_push_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.second |-> push.first)
    else $error("second result pushed without first");

  // A rotation leaves the fill count alone.
  a_rotate_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op == rrts_pkg::OP_STEP && !push.first) |=> count_q == $past(count_q))
    else $error("rotation changed fill count");
`endif

endmodule
